// ----- hw/rtl/txc_pkg.sv -----
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps

package txc_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT_COLOR = 3'd0;
    localparam logic [OP_W-1:0] OP_PUT_KEEP  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL      = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

    // Store access done by the datapath in the current cycle
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_INIT,
        MEM_MOVE,
        MEM_BLANK,
        MEM_PUT,
        MEM_CLEAR,
        MEM_FILL,
        MEM_READ
    } mem_cmd_t;

    // Cursor update
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_STEP,
        CUR_SCROLL,
        CUR_HOME
    } cur_cmd_t;

    // Sweep counter update
    typedef enum logic [1:0] {
        SW_HOLD,
        SW_ZERO,
        SW_INC
    } sw_cmd_t;

    typedef struct packed {
        logic     latch;
        mem_cmd_t mem;
        cur_cmd_t cur;
        sw_cmd_t  sweep;
        logic     load_result;
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cursor_at_end;
        logic            sweep_last;
        logic            move_last;
        logic            out_free;
    } ctl_sts_t;

endpackage

// ----- hw/rtl/txc_ctrl.sv -----
// Sequencer for the text console writer: picks store sweeps and steps per item.
`timescale 1ns / 1ps

module txc_ctrl
    import txc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  ctl_sts_t sts,
    output logic     item_ready,
    output ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_MOVE,
        ST_BLANK,
        ST_PUT,
        ST_CLEAR,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.latch       = 1'b0;
        cmd.mem         = MEM_NONE;
        cmd.cur         = CUR_HOLD;
        cmd.sweep       = SW_HOLD;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.mem = MEM_INIT;
                if (sts.sweep_last)
                begin
                    cmd.sweep  = SW_ZERO;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sweep = SW_INC;
                end
            end
            ST_IDLE:
            begin
                cmd.sweep = SW_ZERO;
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.op)
                    OP_PUT_COLOR, OP_PUT_KEEP:
                        state_next = sts.cursor_at_end ? ST_MOVE : ST_PUT;
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_FILL:  state_next = ST_FILL;
                    OP_READ:  state_next = ST_READ;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_MOVE:
            begin
                cmd.mem = MEM_MOVE;
                if (sts.move_last)
                begin
                    // counter already sits on the first cell of the last row
                    state_next = ST_BLANK;
                end
                else
                begin
                    cmd.sweep = SW_INC;
                end
            end
            ST_BLANK:
            begin
                cmd.mem = MEM_BLANK;
                if (sts.sweep_last)
                begin
                    cmd.cur    = CUR_SCROLL;
                    cmd.sweep  = SW_ZERO;
                    state_next = ST_PUT;
                end
                else
                begin
                    cmd.sweep = SW_INC;
                end
            end
            ST_PUT:
            begin
                cmd.mem    = MEM_PUT;
                cmd.cur    = CUR_STEP;
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                cmd.mem = MEM_CLEAR;
                if (sts.sweep_last)
                begin
                    cmd.cur    = CUR_HOME;
                    cmd.sweep  = SW_ZERO;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.sweep = SW_INC;
                end
            end
            ST_FILL:
            begin
                cmd.mem = MEM_FILL;
                if (sts.sweep_last)
                begin
                    cmd.sweep  = SW_ZERO;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.sweep = SW_INC;
                end
            end
            ST_READ:
            begin
                cmd.mem    = MEM_READ;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/txc_datapath.sv -----
// Datapath for the text console writer: cell stores, cursor, sweep counter, result register.
`timescale 1ns / 1ps

module txc_datapath
    import txc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    output ctl_sts_t          sts,
    input  logic [OP_W-1:0]   operation,
    input  logic [BYTE_W-1:0] ch,
    input  logic [BYTE_W-1:0] color,
    input  logic [ADDR_W-1:0] cell_addr,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [ADDR_W-1:0] cursor,
    output logic [BYTE_W-1:0] read_char,
    output logic [BYTE_W-1:0] read_attr
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int CMPW  = (CW > ADDR_W) ? CW : ADDR_W;

    localparam logic [IW-1:0]   LAST_CELL = IW'(CELLS - 1);
    localparam logic [IW-1:0]   LAST_ROW  = IW'(CELLS - COLUMNS);
    localparam logic [IW-1:0]   ROW_STEP  = IW'(COLUMNS);
    localparam logic [CW-1:0]   END_CUR   = CW'(CELLS);
    localparam logic [COLW-1:0] LAST_COL  = COLW'(COLUMNS - 1);

    logic [BYTE_W-1:0] char_mem [CELLS];
    logic [BYTE_W-1:0] attr_mem [CELLS];

    // latched item
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] ch_reg;
    logic [BYTE_W-1:0] color_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [IW-1:0]   sweep_reg;
    logic [IW-1:0]   sweep_next;
    logic [CW-1:0]   cursor_reg;
    logic [CW-1:0]   cursor_next;
    logic [COLW-1:0] col_reg;
    logic [COLW-1:0] col_next;

    logic [BYTE_W-1:0] rd_char_reg;
    logic [BYTE_W-1:0] rd_attr_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] out_cursor_reg;
    logic [BYTE_W-1:0] out_char_reg;
    logic [BYTE_W-1:0] out_attr_reg;

    logic              char_we;
    logic              attr_we;
    logic              char_re;
    logic              attr_re;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     char_raddr;
    logic [BYTE_W-1:0] char_wdata;
    logic [BYTE_W-1:0] attr_wdata;

    logic [CMPW-1:0] addr_ext;
    logic [CMPW-1:0] cursor_ext;
    logic            addr_ok;
    logic            is_newline;

    assign addr_ext   = CMPW'(addr_reg);
    assign cursor_ext = CMPW'(cursor_reg);
    assign addr_ok    = (addr_ext < CMPW'(CELLS));
    assign is_newline = (ch_reg == NEWLINE_CHAR);

    assign sts.op            = op_reg;
    assign sts.cursor_at_end = (cursor_reg == END_CUR);
    assign sts.sweep_last    = (sweep_reg == LAST_CELL);
    assign sts.move_last     = (sweep_reg == LAST_ROW);
    assign sts.out_free      = !out_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= operation;
            ch_reg    <= ch;
            color_reg <= color;
            addr_reg  <= cell_addr;
        end
    end

    // store port selection
    always_comb
    begin
        char_we    = 1'b0;
        attr_we    = 1'b0;
        char_re    = 1'b0;
        attr_re    = 1'b0;
        wr_addr    = sweep_reg;
        char_raddr = addr_ext[IW-1:0];
        char_wdata = BLANK_CHAR;
        attr_wdata = color_reg;
        case (cmd.mem)
            MEM_INIT:
            begin
                char_we    = 1'b1;
                attr_we    = 1'b1;
                attr_wdata = '0;
            end
            MEM_MOVE:
            begin
                // read one row below, write the cell read last cycle
                char_re    = !sts.move_last;
                char_raddr = sweep_reg + ROW_STEP;
                char_we    = (sweep_reg != '0);
                wr_addr    = sweep_reg - IW'(1);
                char_wdata = rd_char_reg;
            end
            MEM_BLANK, MEM_CLEAR:
            begin
                char_we = 1'b1;
            end
            MEM_PUT:
            begin
                wr_addr    = cursor_reg[IW-1:0];
                char_we    = !is_newline;
                attr_we    = !is_newline && (op_reg == OP_PUT_COLOR);
                char_wdata = ch_reg;
            end
            MEM_FILL:
            begin
                attr_we = 1'b1;
            end
            MEM_READ:
            begin
                char_re = addr_ok;
                attr_re = addr_ok;
            end
            default:
            begin
                char_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (char_we)
        begin
            char_mem[wr_addr] <= char_wdata;
        end
        if (char_re)
        begin
            rd_char_reg <= char_mem[char_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (attr_we)
        begin
            attr_mem[wr_addr] <= attr_wdata;
        end
        if (attr_re)
        begin
            rd_attr_reg <= attr_mem[addr_ext[IW-1:0]];
        end
    end

    always_comb
    begin
        case (cmd.sweep)
            SW_ZERO: sweep_next = '0;
            SW_INC:  sweep_next = sweep_reg + IW'(1);
            default: sweep_next = sweep_reg;
        endcase
    end

    // cursor kept with its column so no modulo is needed
    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        case (cmd.cur)
            CUR_STEP:
            begin
                if (is_newline)
                begin
                    cursor_next = cursor_reg + CW'(COLUMNS) - CW'(col_reg);
                    col_next    = '0;
                end
                else
                begin
                    cursor_next = cursor_reg + CW'(1);
                    col_next    = (col_reg == LAST_COL) ? '0 : col_reg + COLW'(1);
                end
            end
            CUR_SCROLL:
            begin
                cursor_next = CW'(CELLS - COLUMNS);
                col_next    = '0;
            end
            CUR_HOME:
            begin
                cursor_next = '0;
                col_next    = '0;
            end
            default:
            begin
                cursor_next = cursor_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            cursor_reg    <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_cursor_reg <= cursor_ext[ADDR_W-1:0];
            if ((op_reg == OP_READ) && addr_ok)
            begin
                out_char_reg <= rd_char_reg;
                out_attr_reg <= rd_attr_reg;
            end
            else
            begin
                out_char_reg <= '0;
                out_attr_reg <= '0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign cursor       = out_cursor_reg;
    assign read_char    = out_char_reg;
    assign read_attr    = out_attr_reg;

endmodule

// ----- hw/rtl/text_console_writer_core.sv -----
// Top level of the text console writer: sequencer plus datapath.
`timescale 1ns / 1ps

// Text console engine holding a COLUMNS x ROWS screen of character and
// attribute bytes in two single-port-write stores, plus a cursor. Each
// accepted item gives exactly one result item carrying the cursor and, for
// a read of an address on the screen, the addressed cell. After reset the
// block runs a clearing pass over all COLUMNS*ROWS cells that sets
// characters to spaces and attributes to zero; item_ready stays low until
// it ends. Items are handled one at a time: a put or read goes through
// accept, decode, store access and result load; an unused code has no
// store access. A put that finds the cursor past the end first scrolls:
// one pipelined read-then-write step per moved cell through the single
// character store write port, then one blanking write per cell of the last
// row. Clear and fill sweep every cell once.
// The result sits in an output register, so a stalled consumer only blocks
// the block at the end of the following item.

module text_console_writer_core
    import txc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [OP_W-1:0]   operation,
    input  logic [BYTE_W-1:0] ch,
    input  logic [BYTE_W-1:0] color,
    input  logic [ADDR_W-1:0] cell_addr,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [ADDR_W-1:0] cursor,
    output logic [BYTE_W-1:0] read_char,
    output logic [BYTE_W-1:0] read_attr
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // sequencer: one state per phase of an item
    txc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .sts        (sts),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    // stores, cursor and result register
    txc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .ch           (ch),
        .color        (color),
        .cell_addr    (cell_addr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cursor       (cursor),
        .read_char    (read_char),
        .read_attr    (read_attr)
    );

endmodule
